// File: hdl/uart_rf_pkg.sv
// Shared types and constants for the 16550-style UART register file.
// Used by the receive cells, the receive chain and the top level.
package uart_rf_pkg;

    // item operations
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // register offsets
    localparam logic [2:0] OFF_DATA    = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_IIR_FCR = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCR     = 3'd7;

    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
    localparam logic [7:0] IIR_RX_DATA  = 8'h04;
    localparam logic [7:0] IIR_NONE     = 8'h01;
    localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;

    // one control word per cycle for the receive chain
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic       overwrite;
        logic [7:0] byte_in;
    } t_rx_ctrl;

    function automatic logic [3:0] trig_level(input logic [1:0] sel);
        logic [3:0] lvl;
        unique case (sel)
            2'd0: lvl = 4'd1;
            2'd1: lvl = 4'd4;
            2'd2: lvl = 4'd8;
            default: lvl = 4'd14;
        endcase
        return lvl;
    endfunction

endpackage

// File: hdl/uart_rf_rx_cell.sv
// One receive FIFO cell: holds a byte, loads from its upper neighbor on a pop, and takes the
// input byte on a push into its slot or, in cell 0, on an overwrite. Depends on uart_rf_pkg.
module uart_rf_rx_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                  i_clk,
    input  uart_rf_pkg::t_rx_ctrl i_ctrl,
    input  logic [CW-1:0]         i_count,
    input  logic [7:0]            i_next_data,
    output logic [7:0]            o_data
);
    import uart_rf_pkg::*;

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.pop) begin
            n_data = i_next_data;
        end else if (i_ctrl.push && i_count == CW'(IDX)) begin
            n_data = i_ctrl.byte_in;
        end else if (i_ctrl.overwrite && IDX == 0) begin
            n_data = i_ctrl.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hdl/uart_rf_rx_chain.sv
// Receive FIFO as a row of shifting cells with a fill count; head sits in cell 0.
// Depends on uart_rf_pkg and uart_rf_rx_cell.
module uart_rf_rx_chain #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uart_rf_pkg::t_rx_ctrl i_ctrl,
    output logic [7:0]            o_head,
    output logic [CW-1:0]         o_count,
    output logic [CW-1:0]         o_count_next
);
    import uart_rf_pkg::*;

    logic [7:0]    w_data [DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = 8'h00;
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        uart_rf_rx_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_count     (r_count),
            .i_next_data (w_next),
            .o_data      (w_data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end else if (i_ctrl.push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head       = w_data[0];
    assign o_count      = r_count;
    assign o_count_next = n_count;

endmodule

// File: hdl/uart_16550_register_file_core.sv
// Top level of the 16550-style UART register file: registers, decode, output stage.
// Depends on uart_rf_pkg and uart_rf_rx_chain.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------------
//  in      | i_valid | o_ready | i_operation, i_offset, i_write_data, i_line_byte
//  out     | o_valid | i_ready | o_read_data, o_tx_valid, o_tx_byte, o_irq
//
// Each transfer is decoded and applied combinationally; its result is registered in the output
// register, so one item per cycle is sustained while the output is not stalled.
// The receive FIFO shifts one cell toward the head on each pop.
// Reset (synchronous, active low) clears the control registers, the output valid flag and the FIFO fill count.
// A stalled output holds the result and stops input only while it is not taken.
module uart_16550_register_file_core #(
    parameter int RX_FIFO_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_offset,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_line_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_irq
);
    import uart_rf_pkg::*;

    localparam int CW = $clog2(RX_FIFO_DEPTH + 1);

    logic [7:0] r_dll, n_dll;
    logic [7:0] r_dlh, n_dlh;
    logic [3:0] r_ier, n_ier;
    logic [7:0] r_lcr, n_lcr;
    logic [4:0] r_mcr, n_mcr;
    logic [2:0] r_fcr, n_fcr;
    logic       r_ovr, n_ovr;
    logic [7:0] r_scr, n_scr;

    logic       r_out_valid;
    logic [7:0] r_read_data, n_read_data;
    logic       r_tx_valid, n_tx_valid;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic       r_irq, n_irq;

    t_rx_ctrl      w_ctrl;
    logic [7:0]    w_head;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_count_next;

    logic w_fire;
    logic w_dlab;
    logic w_loop;
    logic w_full;
    logic w_pend_now;

    // receive interrupt condition, trigger level clamped to the FIFO depth
    function automatic logic rx_pending(input logic [3:0] ier, input logic [2:0] fcr,
                                        input logic [CW-1:0] cnt);
        logic [3:0] lvl;
        lvl = fcr[0] ? trig_level(fcr[2:1]) : 4'd1;
        return ier[0] && ((9'(cnt) >= 9'(lvl)) || (cnt == CW'(RX_FIFO_DEPTH)));
    endfunction

    assign o_ready    = !r_out_valid || i_ready;
    assign w_fire     = i_valid && o_ready;
    assign w_dlab     = r_lcr[7];
    assign w_loop     = r_mcr[4];
    assign w_full     = r_fcr[0] ? (w_count == CW'(RX_FIFO_DEPTH)) : (w_count != '0);
    assign w_pend_now = rx_pending(r_ier, r_fcr, w_count);

    always_comb begin
        logic       push_req;
        logic [7:0] push_byte;
        n_dll = r_dll;
        n_dlh = r_dlh;
        n_ier = r_ier;
        n_lcr = r_lcr;
        n_mcr = r_mcr;
        n_fcr = r_fcr;
        n_ovr = r_ovr;
        n_scr = r_scr;
        n_read_data = 8'h00;
        n_tx_valid  = 1'b0;
        n_tx_byte   = 8'h00;
        w_ctrl      = '0;
        push_req    = 1'b0;
        push_byte   = i_write_data;

        if (w_fire) begin
            unique case (i_operation)
                OP_READ: begin
                    unique case (i_offset)
                        OFF_DATA: begin
                            if (w_dlab) begin
                                n_read_data = r_dll;
                            end else if (w_count != '0) begin
                                n_read_data = w_head;
                                w_ctrl.pop  = 1'b1;
                            end
                        end
                        OFF_IER:     n_read_data = w_dlab ? r_dlh : {4'h0, r_ier};
                        OFF_IIR_FCR: begin
                            n_read_data = (w_pend_now ? IIR_RX_DATA : IIR_NONE)
                                        | (r_fcr[0] ? IIR_FIFO_ON : 8'h00);
                        end
                        OFF_LCR:     n_read_data = r_lcr;
                        OFF_MCR:     n_read_data = {3'b000, r_mcr};
                        OFF_LSR: begin
                            n_read_data = LSR_TX_EMPTY | {6'b0, r_ovr, (w_count != '0)};
                            n_ovr       = 1'b0;
                        end
                        OFF_MSR: begin
                            if (w_loop) begin
                                n_read_data = {r_mcr[3], r_mcr[2], r_mcr[0], r_mcr[1], 4'h0};
                            end
                        end
                        default:     n_read_data = r_scr;
                    endcase
                end
                OP_WRITE: begin
                    unique case (i_offset)
                        OFF_DATA: begin
                            if (w_dlab) begin
                                n_dll = i_write_data;
                            end else if (w_loop) begin
                                push_req = 1'b1;
                            end else begin
                                n_tx_valid = 1'b1;
                                n_tx_byte  = i_write_data;
                            end
                        end
                        OFF_IER: begin
                            if (w_dlab) begin
                                n_dlh = i_write_data;
                            end else begin
                                n_ier = i_write_data[3:0];
                            end
                        end
                        OFF_IIR_FCR: begin
                            if (i_write_data[0] != r_fcr[0]) begin
                                w_ctrl.clear = 1'b1;
                            end
                            if (i_write_data[0]) begin
                                if (i_write_data[1]) begin
                                    w_ctrl.clear = 1'b1;
                                end
                                n_fcr = {i_write_data[7:6], 1'b1};
                            end else begin
                                n_fcr = {r_fcr[2:1], 1'b0};
                            end
                        end
                        OFF_LCR: n_lcr = i_write_data;
                        OFF_MCR: n_mcr = i_write_data[4:0];
                        OFF_SCR: n_scr = i_write_data;
                        default: ;
                    endcase
                end
                OP_LINE: begin
                    if (!w_loop) begin
                        push_req  = 1'b1;
                        push_byte = i_line_byte;
                    end
                end
                default: ;
            endcase
        end

        // accept the byte while there is room, otherwise flag overrun and, with the FIFO off, overwrite the held byte
        w_ctrl.byte_in = push_byte;
        if (push_req) begin
            if (!w_full) begin
                w_ctrl.push = 1'b1;
            end else begin
                n_ovr = 1'b1;
                w_ctrl.overwrite = !r_fcr[0];
            end
        end
    end

    assign n_irq = rx_pending(n_ier, n_fcr, w_count_next) && n_mcr[3];

    uart_rf_rx_chain #(.DEPTH(RX_FIFO_DEPTH), .CW(CW)) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_head       (w_head),
        .o_count      (w_count),
        .o_count_next (w_count_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dll       <= '0;
            r_dlh       <= '0;
            r_ier       <= '0;
            r_lcr       <= '0;
            r_mcr       <= '0;
            r_fcr       <= '0;
            r_ovr       <= 1'b0;
            r_scr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dll <= n_dll;
            r_dlh <= n_dlh;
            r_ier <= n_ier;
            r_lcr <= n_lcr;
            r_mcr <= n_mcr;
            r_fcr <= n_fcr;
            r_ovr <= n_ovr;
            r_scr <= n_scr;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_data <= n_read_data;
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
            r_irq       <= n_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_irq       = r_irq;

endmodule

// File: tb/uart_16550_register_file_core_tb.sv
// Self-checking bench for uart_16550_register_file_core: directed accesses, then random
// bus and line traffic with random gaps on both channels, checked by a scoreboard model.
// Depends on uart_rf_pkg and the register file RTL.
module uart_16550_register_file_core_tb;
    import uart_rf_pkg::*;

    localparam int RX_DEPTH = 16;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
    } t_uart_resp;

    class uart_rf_scoreboard;
        logic [7:0] div_lo = '0;
        logic [7:0] div_hi = '0;
        logic [3:0] ier = '0;
        logic [7:0] lcr = '0;
        logic [4:0] mcr = '0;
        logic [2:0] fcr = '0;   // bit 0 enable, bits 2:1 trigger select
        logic [7:0] scratch = '0;
        logic [7:0] rx_mem [RX_DEPTH];
        int unsigned rx_count = 0;
        int unsigned rx_head = 0;
        bit overrun = 1'b0;
        t_uart_resp expected_responses[$];
        int unsigned mismatches = 0;

        function bit rx_irq_pending();
            int unsigned lvl;
            lvl = 1;
            if (fcr[0]) begin
                case (fcr[2:1])
                    2'd0: lvl = 1;
                    2'd1: lvl = 4;
                    2'd2: lvl = 8;
                    default: lvl = 14;
                endcase
            end
            if (lvl > RX_DEPTH) lvl = RX_DEPTH;
            return ier[0] && (rx_count >= lvl);
        endfunction

        function void rx_push(logic [7:0] b);
            int unsigned cap;
            cap = fcr[0] ? RX_DEPTH : 1;
            if (rx_count < cap) begin
                rx_mem[(rx_head + rx_count) % RX_DEPTH] = b;
                rx_count++;
            end else begin
                overrun = 1'b1;
                // with the FIFO off the holding register takes the newest byte
                if (!fcr[0]) rx_mem[rx_head] = b;
            end
        endfunction

        function void note_access(logic [1:0] op, logic [2:0] off, logic [7:0] wd,
                                  logic [7:0] lb);
            t_uart_resp r;
            logic dlab;
            r = '0;
            dlab = lcr[7];
            case (op)
                OP_READ: begin
                    case (off)
                        OFF_DATA: begin
                            if (dlab) begin
                                r.read_data = div_lo;
                            end else if (rx_count != 0) begin
                                r.read_data = rx_mem[rx_head];
                                rx_head = (rx_head + 1) % RX_DEPTH;
                                rx_count--;
                            end
                        end
                        OFF_IER: r.read_data = dlab ? div_hi : {4'b0, ier};
                        OFF_IIR_FCR: r.read_data = (rx_irq_pending() ? IIR_RX_DATA : IIR_NONE)
                                                   | (fcr[0] ? IIR_FIFO_ON : 8'h00);
                        OFF_LCR: r.read_data = lcr;
                        OFF_MCR: r.read_data = {3'b0, mcr};
                        OFF_LSR: begin
                            r.read_data = LSR_TX_EMPTY | {6'b0, overrun, rx_count != 0};
                            overrun = 1'b0;
                        end
                        OFF_MSR: begin
                            // loopback: DCD=OUT2, RI=OUT1, DSR=DTR, CTS=RTS
                            if (mcr[4]) r.read_data = {mcr[3], mcr[2], mcr[0], mcr[1], 4'b0};
                        end
                        default: r.read_data = scratch;
                    endcase
                end
                OP_WRITE: begin
                    case (off)
                        OFF_DATA: begin
                            if (dlab) begin
                                div_lo = wd;
                            end else if (mcr[4]) begin
                                rx_push(wd);
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = wd;
                            end
                        end
                        OFF_IER: begin
                            if (dlab) div_hi = wd;
                            else ier = wd[3:0];
                        end
                        OFF_IIR_FCR: begin
                            // enable change or clear-with-enable empties the receive side
                            if ((wd[0] != fcr[0]) || (wd[0] && wd[1])) begin
                                rx_count = 0;
                                rx_head = 0;
                            end
                            if (wd[0]) fcr = {wd[7:6], 1'b1};
                            else fcr[0] = 1'b0;
                        end
                        OFF_LCR: lcr = wd;
                        OFF_MCR: mcr = wd[4:0];
                        OFF_SCR: scratch = wd;
                        default: ;
                    endcase
                end
                OP_LINE: begin
                    if (!mcr[4]) rx_push(lb);
                end
                default: ;
            endcase
            r.irq = rx_irq_pending() && mcr[3];
            expected_responses.push_back(r);
        endfunction

        function void compare_field(string what, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                             $time, what, want, got);
            end
        endfunction

        function void check_response(logic [7:0] rd, logic txv, logic [7:0] txb, logic irq);
            t_uart_resp want;
            if (expected_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no pending access: expected none, got rd 0x%0h",
                             $time, rd);
                return;
            end
            want = expected_responses.pop_front();
            compare_field("read_data", want.read_data, rd);
            compare_field("tx_valid", {7'b0, want.tx_valid}, {7'b0, txv});
            compare_field("tx_byte", want.tx_byte, txb);
            compare_field("irq", {7'b0, want.irq}, {7'b0, irq});
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_operation;
    logic [2:0] i_offset;
    logic [7:0] i_write_data;
    logic [7:0] i_line_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_read_data;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_irq;

    uart_rf_scoreboard regfile_sb;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit steady_flow = 1'b0;

    uart_16550_register_file_core #(
        .RX_FIFO_DEPTH(RX_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_operation(i_operation),
        .i_offset(i_offset),
        .i_write_data(i_write_data),
        .i_line_byte(i_line_byte),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_read_data(o_read_data),
        .o_tx_valid(o_tx_valid),
        .o_tx_byte(o_tx_byte),
        .o_irq(o_irq)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_access(logic [1:0] op, logic [2:0] off, logic [7:0] wd,
                               logic [7:0] lb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_offset <= off;
        i_write_data <= wd;
        i_line_byte <= lb;
        do @(posedge i_clk); while (!o_ready);
        regfile_sb.note_access(op, off, wd, lb);
        items_sent++;
    endtask

    // hold off the input until every outstanding result is back
    task automatic drain_responses();
        i_valid <= 1'b0;
        while (regfile_sb.expected_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_burst();
        int kind;
        int n;
        logic [7:0] v;
        kind = $urandom_range(0, 10);
        case (kind)
            0, 1, 2: begin
                n = $urandom_range(1, 20);
                repeat (n) send_access(OP_LINE, 3'($urandom), 8'($urandom), 8'($urandom));
            end
            3, 4: begin
                n = $urandom_range(1, 18);
                repeat (n) send_access(OP_READ, OFF_DATA, 8'($urandom), 8'($urandom));
            end
            5: begin
                v = 8'($urandom);
                case ($urandom_range(0, 4))
                    0: send_access(OP_WRITE, OFF_IIR_FCR, v, 8'($urandom));
                    1: begin
                        v[7] = ($urandom_range(0, 3) == 0);
                        send_access(OP_WRITE, OFF_LCR, v, 8'($urandom));
                    end
                    2: begin
                        v[4] = ($urandom_range(0, 3) == 0);
                        send_access(OP_WRITE, OFF_MCR, v, 8'($urandom));
                    end
                    3: send_access(OP_WRITE, OFF_IER, v, 8'($urandom));
                    default: send_access(OP_WRITE, OFF_SCR, v, 8'($urandom));
                endcase
            end
            6: begin
                v = 8'($urandom);
                v[4] = 1'b1;
                send_access(OP_WRITE, OFF_MCR, v, 8'($urandom));
                n = $urandom_range(1, 18);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0)
                        send_access(OP_LINE, 3'($urandom), 8'($urandom), 8'($urandom));
                    else
                        send_access(OP_WRITE, OFF_DATA, 8'($urandom), 8'($urandom));
                end
                n = $urandom_range(0, 6);
                repeat (n) send_access(OP_READ, OFF_DATA, 8'($urandom), 8'($urandom));
                send_access(OP_READ, OFF_MSR, 8'($urandom), 8'($urandom));
                v = 8'($urandom);
                v[4] = 1'b0;
                send_access(OP_WRITE, OFF_MCR, v, 8'($urandom));
            end
            7: begin
                n = $urandom_range(1, 5);
                repeat (n) send_access(OP_READ, 3'($urandom_range(1, 7)), 8'($urandom),
                                       8'($urandom));
            end
            8: begin
                v = 8'($urandom);
                v[7] = 1'b1;
                send_access(OP_WRITE, OFF_LCR, v, 8'($urandom));
                n = $urandom_range(1, 4);
                repeat (n) send_access(2'($urandom_range(0, 1)), 3'($urandom_range(0, 1)),
                                       8'($urandom), 8'($urandom));
                v[7] = 1'b0;
                send_access(OP_WRITE, OFF_LCR, v, 8'($urandom));
            end
            9: begin
                n = $urandom_range(1, 6);
                repeat (n) send_access(OP_WRITE, OFF_DATA, 8'($urandom), 8'($urandom));
            end
            default: begin
                if ($urandom_range(0, 49) == 0)
                    send_access(OP_UNKNOWN, 3'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_access(2'($urandom_range(0, 2)), 3'($urandom), 8'($urandom),
                                8'($urandom));
            end
        endcase
    endtask

    // result side: random stalls, sampled at the edge
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                regfile_sb.check_response(o_read_data, o_tx_valid, o_tx_byte, o_irq);
            if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned last_drain;
        regfile_sb = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_operation <= OP_READ;
        i_offset <= OFF_DATA;
        i_write_data <= 8'h00;
        i_line_byte <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(OP_READ, OFF_LSR, 8'h00, 8'h00);
        send_access(OP_READ, OFF_DATA, 8'h00, 8'h00);     // empty receive read
        send_access(OP_WRITE, OFF_SCR, 8'hFF, 8'h00);
        send_access(OP_READ, OFF_SCR, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_IER, 8'hFF, 8'h00);
        send_access(OP_WRITE, OFF_MCR, 8'h08, 8'h00);
        send_access(OP_LINE, OFF_DATA, 8'h00, 8'hFF);
        send_access(OP_LINE, OFF_SCR, 8'hFF, 8'h00);     // holding register overwritten
        send_access(OP_READ, OFF_LSR, 8'h00, 8'h00);
        send_access(OP_READ, OFF_IIR_FCR, 8'h00, 8'h00);
        send_access(OP_READ, OFF_DATA, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_IIR_FCR, 8'hC7, 8'h00);
        send_access(OP_WRITE, OFF_IIR_FCR, 8'h06, 8'h00); // disable only
        send_access(OP_WRITE, OFF_LCR, 8'hFF, 8'h00);
        send_access(OP_WRITE, OFF_DATA, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_IER, 8'hAE, 8'h00);
        send_access(OP_READ, OFF_DATA, 8'h00, 8'h00);
        send_access(OP_READ, OFF_IER, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_LCR, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_MCR, 8'hFF, 8'h00);
        send_access(OP_READ, OFF_MSR, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_DATA, 8'h80, 8'h00);   // loopback push
        send_access(OP_LINE, OFF_DATA, 8'h00, 8'hAA);    // ignored in loopback
        send_access(OP_WRITE, OFF_LSR, 8'hFF, 8'h00);
        send_access(OP_WRITE, OFF_MSR, 8'hFF, 8'h00);
        send_access(OP_UNKNOWN, 3'h7, 8'hFF, 8'hFF);
        send_access(OP_WRITE, OFF_MCR, 8'h00, 8'h00);
        send_access(OP_WRITE, OFF_DATA, 8'h7F, 8'h00);   // transmit
        drain_responses();

        last_drain = items_sent;
        while (items_sent < ITEM_TARGET) begin
            steady_flow = ($urandom_range(0, 7) == 0);
            random_burst();
            if (items_sent - last_drain >= 400) begin
                drain_responses();
                last_drain = items_sent;
            end
        end
        steady_flow = 1'b0;
        i_valid <= 1'b0;

        while (regfile_sb.expected_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (regfile_sb.mismatches == 0 && regfile_sb.expected_responses.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
